>>> rtl/core/refcounted_page_allocator_defines.svh
// assertion macros for the refcounted page allocator
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define RCPA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcpa: same-cycle check failed");
`define RCPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcpa: next-cycle check failed");
`else
`define RCPA_ASSERT_IMPL(name, ante, cons)
`define RCPA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/core/rcpa_pkg.sv
// shared types and constants for the refcounted page allocator
package rcpa_pkg;

    localparam int ADDR_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int REF_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int PAGE_SHIFT  = 12;
    localparam int OFF_W       = ADDR_W - PAGE_SHIFT;
    localparam int EXT_W       = ADDR_W + 2;

    localparam int NUM_PAGES_DEF  = 32768;
    localparam int COUNT_BITS_DEF = 8;

    localparam logic [ADDR_W-1:0] MEM_BASE_RST   = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] FIRST_FREE_RST = 32'h8010_0000;
    localparam logic [ADDR_W-1:0] MEM_TOP_RST    = 32'h8800_0000;

    typedef enum logic [FUNC_W-1:0] {
        FN_INIT   = 3'd0,
        FN_ALLOC  = 3'd1,
        FN_FREE   = 3'd2,
        FN_INCREF = 3'd3,
        FN_QUERY  = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_OOM     = 3'd1,
        STS_INVALID = 3'd2,
        STS_DOUBLE  = 3'd3,
        STS_CORRUPT = 3'd4,
        STS_SAT     = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEM_BASE   = 2'd0,
        CFG_FIRST_FREE = 2'd1,
        CFG_MEM_TOP    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_EXEC,
        ST_SETUP,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic range_ok;
        logic free_ok;
    } addr_chk_t;

endpackage

>>> rtl/core/rcpa_ram.sv
// generic single-write single-read ram with registered read data
module rcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/rcpa_addr_dec.sv
// physical address to page index decode with range and alignment checks
module rcpa_addr_dec
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic [ADDR_W-1:0]            addr,
    input  logic [ADDR_W-1:0]            mem_base,
    input  logic [ADDR_W-1:0]            first_free_addr,
    input  logic [ADDR_W-1:0]            mem_top,
    output logic [$clog2(NUM_PAGES)-1:0] idx,
    output addr_chk_t                    chk
);

    localparam int IDX_W = $clog2(NUM_PAGES);

    logic [ADDR_W-1:0] diff;
    logic [OFF_W-1:0]  off;
    logic              in_pages;

    always_comb
    begin
        diff         = addr - mem_base;
        off          = diff[ADDR_W-1:PAGE_SHIFT];
        in_pages     = {1'b0, off} < (OFF_W + 1)'(NUM_PAGES);
        idx          = off[IDX_W-1:0];
        chk.range_ok = (addr >= mem_base) && (addr < mem_top) && in_pages;
        chk.free_ok  = chk.range_ok && (addr[PAGE_SHIFT-1:0] == '0)
                       && (addr >= first_free_addr);
    end

endmodule

>>> rtl/core/rcpa_engine.sv
// command sequencer: count and free-stack read-modify-write, init sweep
module rcpa_engine
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [ADDR_W-1:0]        phys_addr,
    input  logic [ADDR_W-1:0]        mem_base,
    input  logic [ADDR_W-1:0]        first_free_addr,
    input  logic [ADDR_W-1:0]        mem_top,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [ADDR_W-1:0]        page_addr,
    output logic [REF_W-1:0]         ref_count,
    output logic                     page_released,
    output logic                             cnt_we,
    output logic [$clog2(NUM_PAGES)-1:0]     cnt_waddr,
    output logic [COUNT_BITS-1:0]            cnt_wdata,
    output logic                             cnt_re,
    output logic [$clog2(NUM_PAGES)-1:0]     cnt_raddr,
    input  logic [COUNT_BITS-1:0]            cnt_rdata,
    output logic                             stk_we,
    output logic [$clog2(NUM_PAGES)-1:0]     stk_waddr,
    output logic [$clog2(NUM_PAGES)-1:0]     stk_wdata,
    output logic                             stk_re,
    output logic [$clog2(NUM_PAGES)-1:0]     stk_raddr,
    input  logic [$clog2(NUM_PAGES)-1:0]     stk_rdata
);

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
    localparam logic [EXT_W-1:0]      PAGE_EXT = EXT_W'(1) << PAGE_SHIFT;
    localparam logic [EXT_W-1:0]      ROUND_UP = (PAGE_EXT << 1) - EXT_W'(1);
    localparam logic [EXT_W-1:0]      PAGE_MSK = ~(PAGE_EXT - EXT_W'(1));

    state_t               state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [IDX_W-1:0]     idx_reg;
    addr_chk_t            chk_reg;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [IDX_W-1:0]     sweep_cnt_reg;
    logic                 push_en_reg;
    logic [EXT_W-1:0]     pe_reg;
    logic [EXT_W-1:0]     lo_reg;

    logic                 rsp_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [ADDR_W-1:0]    page_reg;
    logic [REF_W-1:0]     count_reg;
    logic                 rel_reg;

    logic [IDX_W-1:0]     dec_idx;
    addr_chk_t            dec_chk;

    logic                 accept;
    logic                 commit;
    logic                 sweep_last;
    logic                 sweep_push;
    logic                 stk_empty;
    status_t              res_status;
    logic [ADDR_W-1:0]    res_page;
    logic [COUNT_BITS-1:0] res_count;
    logic                 res_rel;
    logic [COUNT_BITS-1:0] cnt_dec;

    rcpa_addr_dec #(
        .NUM_PAGES (NUM_PAGES)
    ) u_addr_dec (
        .addr            (addr_reg),
        .mem_base        (mem_base),
        .first_free_addr (first_free_addr),
        .mem_top         (mem_top),
        .idx             (dec_idx),
        .chk             (dec_chk)
    );

    assign accept     = cmd_valid && cmd_ready;
    assign commit     = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign sweep_last = sweep_cnt_reg == IDX_W'(NUM_PAGES - 1);
    assign stk_empty  = depth_reg == '0;
    assign cnt_dec    = cnt_rdata - CNT_ONE;
    assign sweep_push = push_en_reg && (pe_reg >= lo_reg)
                        && (pe_reg <= {2'b00, mem_top});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (func == FN_INIT) ? ST_SETUP : ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = (func_reg == FN_ALLOC && !stk_empty) ? ST_POP : ST_EXEC;
            end
            ST_POP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = push_en_reg ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls and result
    always_comb
    begin
        cmd_ready  = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = idx_reg;
        cnt_wdata  = '0;
        cnt_re     = 1'b0;
        cnt_raddr  = dec_idx;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[IDX_W-1:0];
        stk_wdata  = idx_reg;
        stk_re     = 1'b0;
        stk_raddr  = IDX_W'(depth_reg - DEPTH_W'(1));
        depth_next = depth_reg;
        res_status = STS_OK;
        res_page   = '0;
        res_count  = '0;
        res_rel    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            ST_DECODE:
            begin
                cnt_re = 1'b1;
                stk_re = (func_reg == FN_ALLOC) && !stk_empty;
            end
            ST_POP:
            begin
                cnt_re    = 1'b1;
                cnt_raddr = stk_rdata;
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FN_ALLOC:
                    begin
                        if (stk_empty)
                        begin
                            res_status = STS_OOM;
                        end
                        else
                        begin
                            depth_next = commit ? depth_reg - DEPTH_W'(1) : depth_reg;
                            if (cnt_rdata != '0)
                            begin
                                // popped page still referenced: drop it
                                res_status = STS_CORRUPT;
                                res_count  = cnt_rdata;
                            end
                            else
                            begin
                                cnt_we    = commit;
                                cnt_wdata = CNT_ONE;
                                res_page  = mem_base + (ADDR_W'(idx_reg) << PAGE_SHIFT);
                                res_count = CNT_ONE;
                            end
                        end
                    end
                    FN_FREE:
                    begin
                        if (!chk_reg.free_ok)
                        begin
                            res_status = STS_INVALID;
                        end
                        else if (cnt_rdata == '0)
                        begin
                            res_status = STS_DOUBLE;
                        end
                        else
                        begin
                            cnt_we    = commit;
                            cnt_wdata = cnt_dec;
                            res_count = cnt_dec;
                            if (cnt_dec == '0 && depth_reg < DEPTH_W'(NUM_PAGES))
                            begin
                                stk_we     = commit;
                                depth_next = commit ? depth_reg + DEPTH_W'(1) : depth_reg;
                                res_rel    = 1'b1;
                            end
                        end
                    end
                    FN_INCREF:
                    begin
                        if (!chk_reg.range_ok)
                        begin
                            res_status = STS_INVALID;
                        end
                        else if (cnt_rdata == CNT_MAX)
                        begin
                            res_status = STS_SAT;
                            res_count  = cnt_rdata;
                        end
                        else
                        begin
                            cnt_we    = commit;
                            cnt_wdata = cnt_rdata + CNT_ONE;
                            res_count = cnt_rdata + CNT_ONE;
                        end
                    end
                    FN_QUERY:
                    begin
                        if (!chk_reg.range_ok)
                        begin
                            res_status = STS_INVALID;
                        end
                        else
                        begin
                            res_count = cnt_rdata;
                        end
                    end
                    default:
                    begin
                        res_status = STS_OK;
                    end
                endcase
            end
            ST_SETUP:
            begin
                depth_next = '0;
            end
            ST_SWEEP:
            begin
                // clear one count per cycle, push pages of the managed window in order
                cnt_we     = 1'b1;
                cnt_waddr  = sweep_cnt_reg;
                cnt_wdata  = '0;
                stk_we     = sweep_push;
                stk_wdata  = sweep_cnt_reg;
                depth_next = depth_reg + DEPTH_W'(sweep_push);
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            depth_reg     <= '0;
            sweep_cnt_reg <= '0;
            push_en_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (state_reg == ST_SETUP)
            begin
                sweep_cnt_reg <= '0;
                push_en_reg   <= 1'b1;
            end
            else if (state_reg == ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            addr_reg <= phys_addr;
        end
        if (state_reg == ST_DECODE)
        begin
            idx_reg <= dec_idx;
            chk_reg <= dec_chk;
        end
        if (state_reg == ST_POP)
        begin
            idx_reg <= stk_rdata;
        end
        if (state_reg == ST_SETUP)
        begin
            // track page end address: first aligned page at or above the base
            pe_reg <= ({2'b00, mem_base} + ROUND_UP) & PAGE_MSK;
            lo_reg <= ({2'b00, first_free_addr} + ROUND_UP) & PAGE_MSK;
        end
        else if (state_reg == ST_SWEEP)
        begin
            pe_reg <= pe_reg + PAGE_EXT;
        end
        if (commit)
        begin
            status_reg <= res_status;
            page_reg   <= res_page;
            count_reg  <= REF_W'(res_count);
            rel_reg    <= res_rel;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign page_addr     = page_reg;
    assign ref_count     = count_reg;
    assign page_released = rel_reg;

endmodule

>>> rtl/core/refcounted_page_allocator.sv
// refcounted page allocator top level: config registers, engine and state memories
//
// commands enter on cmd_valid/cmd_ready with func and phys_addr; each beat gives
// exactly one response beat on rsp_valid/rsp_ready carrying status, page_addr,
// ref_count and page_released.
// the engine works on one command at a time. free, incref and query go from accept
// through address decode with count read to write back; alloc adds a pop step
// before the count read, since the popped page index must come out of the stack
// memory before its count can be read, and skips it when the stack is empty. init
// sweeps every page index once, one count memory row per cycle, then responds.
// after reset the same sweep clears the count memory while cmd_ready stays low.
// the stack depth starts at zero.
// a finished response sits in an output register; the next command is accepted
// meanwhile, and the engine holds its write back until that register is taken.
// config writes (cfg_we, cfg_index, cfg_wdata) act at once and belong only to
// idle periods.
`include "refcounted_page_allocator_defines.svh"
module refcounted_page_allocator
    import rcpa_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [ADDR_W-1:0]    phys_addr,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [ADDR_W-1:0]    page_addr,
    output logic [REF_W-1:0]     ref_count,
    output logic                 page_released
);

    localparam int IDX_W = $clog2(NUM_PAGES);

    logic [ADDR_W-1:0]     mem_base_reg;
    logic [ADDR_W-1:0]     first_free_reg;
    logic [ADDR_W-1:0]     mem_top_reg;

    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  cnt_re;
    logic [IDX_W-1:0]      cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic                  stk_we;
    logic [IDX_W-1:0]      stk_waddr;
    logic [IDX_W-1:0]      stk_wdata;
    logic                  stk_re;
    logic [IDX_W-1:0]      stk_raddr;
    logic [IDX_W-1:0]      stk_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_base_reg   <= MEM_BASE_RST;
            first_free_reg <= FIRST_FREE_RST;
            mem_top_reg    <= MEM_TOP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEM_BASE:   mem_base_reg   <= cfg_wdata;
                CFG_FIRST_FREE: first_free_reg <= cfg_wdata;
                CFG_MEM_TOP:    mem_top_reg    <= cfg_wdata;
                default:        mem_base_reg   <= mem_base_reg;
            endcase
        end
    end

    rcpa_engine #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .func            (func),
        .phys_addr       (phys_addr),
        .mem_base        (mem_base_reg),
        .first_free_addr (first_free_reg),
        .mem_top         (mem_top_reg),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .page_addr       (page_addr),
        .ref_count       (ref_count),
        .page_released   (page_released),
        .cnt_we          (cnt_we),
        .cnt_waddr       (cnt_waddr),
        .cnt_wdata       (cnt_wdata),
        .cnt_re          (cnt_re),
        .cnt_raddr       (cnt_raddr),
        .cnt_rdata       (cnt_rdata),
        .stk_we          (stk_we),
        .stk_waddr       (stk_waddr),
        .stk_wdata       (stk_wdata),
        .stk_re          (stk_re),
        .stk_raddr       (stk_raddr),
        .stk_rdata       (stk_rdata)
    );

    rcpa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rcpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    `RCPA_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
    `RCPA_ASSERT_IMPL(a_release_means_zero, rsp_valid && page_released, (status == STS_OK) && (ref_count == '0))
    `RCPA_ASSERT_IMPL(a_error_no_page, rsp_valid && (status != STS_OK), (page_addr == '0) && !page_released)

endmodule
